// File: sv/mlqs_pkg.sv
// Shared types and constants for the multilevel queue scheduler.
`timescale 1ns / 1ps
`default_nettype none

package mlqs_pkg;

    localparam int LEVELS     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [2:0]  status_t;
    typedef logic [1:0]  level_t;
    typedef logic [7:0]  prio_t;
    typedef logic [15:0] burst_t;
    typedef logic [31:0] time_t;

    localparam status_t ST_ADDED    = 3'd0;
    localparam status_t ST_FULL     = 3'd1;
    localparam status_t ST_REQUEUED = 3'd2;
    localparam status_t ST_DONE     = 3'd3;
    localparam status_t ST_IDLE     = 3'd4;

    localparam level_t LVL_HIGH   = 2'd0;
    localparam level_t LVL_MEDIUM = 2'd1;
    localparam level_t LVL_LOW    = 2'd2;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_RUN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_LIMIT = 2'd2;

    localparam burst_t QUANTUM_RST      = 16'd10;
    localparam prio_t  HIGH_LIMIT_RST   = 8'd3;
    localparam prio_t  MEDIUM_LIMIT_RST = 8'd6;

    // FIFO entry: priority over remaining time
    typedef struct packed {
        prio_t  prio;
        burst_t remaining;
    } task_entry_t;

    typedef struct packed {
        logic capture;  // latch request, read all FIFO heads
        logic commit;   // execute request and load the result register
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    typedef enum logic [1:0] {
        CS_IDLE = 2'b01,
        CS_EXEC = 2'b10
    } ctrl_state_t;

endpackage

`default_nettype wire

// File: sv/mlqs_ctrl.sv
// Controller state machine of the multilevel queue scheduler.
`timescale 1ns / 1ps
`default_nettype none

module mlqs_ctrl
    import mlqs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire dp_stat_t dp_stat,
    output dp_cmd_t       dp_cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        dp_cmd     = '0;
        s_ready    = (state_reg == CS_IDLE);
        unique case (state_reg)
            CS_IDLE: begin
                if (s_valid) begin
                    dp_cmd.capture = 1'b1;
                    state_next     = CS_EXEC;
                end
            end
            CS_EXEC: begin
                // hold until the result register can take the new result
                if (dp_stat.out_free) begin
                    dp_cmd.commit = 1'b1;
                    state_next    = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/mlqs_dpath.sv
// Datapath of the multilevel queue scheduler: FIFOs, pointers, time counter, result register.
`timescale 1ns / 1ps
`default_nettype none

module mlqs_dpath
    import mlqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 128
)(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_operation,
    input  wire logic [7:0]            s_priority_req,
    input  wire logic [15:0]           s_burst_time,
    input  wire dp_cmd_t               dp_cmd,
    output dp_stat_t                   dp_stat,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [2:0]                 m_status,
    output logic [1:0]                 m_level,
    output logic [7:0]                 m_task_priority,
    output logic [31:0]                m_start_time,
    output logic [15:0]                m_run_length,
    output logic [15:0]                m_time_left
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

    // configuration
    burst_t quantum_reg;
    prio_t  high_limit_reg;
    prio_t  medium_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg      <= QUANTUM_RST;
            high_limit_reg   <= HIGH_LIMIT_RST;
            medium_limit_reg <= MEDIUM_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_QUANTUM:      quantum_reg      <= cfg_wdata;
                CFG_HIGH_LIMIT:   high_limit_reg   <= cfg_wdata[7:0];
                CFG_MEDIUM_LIMIT: medium_limit_reg <= cfg_wdata[7:0];
                default:          ;
            endcase
        end
    end

    // latched request
    logic   op_reg;
    prio_t  prio_reg;
    burst_t burst_reg;

    always_ff @(posedge aclk) begin
        if (dp_cmd.capture) begin
            op_reg    <= s_operation;
            prio_reg  <= s_priority_req;
            burst_reg <= s_burst_time;
        end
    end

    // FIFO control state
    logic [PTR_W-1:0] head_reg  [LEVELS];
    logic [PTR_W-1:0] head_next [LEVELS];
    logic [CNT_W-1:0] cnt_reg   [LEVELS];
    logic [CNT_W-1:0] cnt_next  [LEVELS];
    time_t            time_reg;
    time_t            time_next;

    task_entry_t      rdata [LEVELS];
    logic             wr_en [LEVELS];
    logic [PTR_W-1:0] wr_addr;
    task_entry_t      wr_data;

    for (genvar lv = 0; lv < LEVELS; lv++) begin : g_fifo
        task_entry_t mem [QUEUE_DEPTH];

        always_ff @(posedge aclk) begin
            if (wr_en[lv]) begin
                mem[wr_addr] <= wr_data;
            end
        end

        // heads are read on capture; no write occurs in that cycle
        always_ff @(posedge aclk) begin
            if (dp_cmd.capture) begin
                rdata[lv] <= mem[head_reg[lv]];
            end
        end
    end

    // execute logic
    burst_t           q_eff;
    level_t           add_lvl;
    level_t           run_lvl;
    logic             any_task;
    level_t           sel_lvl;
    logic [PTR_W-1:0] sel_head;
    logic [CNT_W-1:0] sel_cnt;
    logic [SUM_W-1:0] tail_sum;
    logic [SUM_W-1:0] tail_wrap;
    task_entry_t      head_entry;
    burst_t           run_len;
    burst_t           left_len;
    logic             do_write;
    status_t          res_status;
    level_t           res_level;
    prio_t            res_prio;
    burst_t           res_run;
    burst_t           res_left;

    always_comb begin
        q_eff = (quantum_reg == '0) ? 16'd1 : quantum_reg;

        priority if (prio_reg <= high_limit_reg) begin
            add_lvl = LVL_HIGH;
        end else if (prio_reg <= medium_limit_reg) begin
            add_lvl = LVL_MEDIUM;
        end else begin
            add_lvl = LVL_LOW;
        end

        any_task = 1'b1;
        priority if (cnt_reg[0] != '0) begin
            run_lvl = LVL_HIGH;
        end else if (cnt_reg[1] != '0) begin
            run_lvl = LVL_MEDIUM;
        end else if (cnt_reg[2] != '0) begin
            run_lvl = LVL_LOW;
        end else begin
            run_lvl  = LVL_HIGH;
            any_task = 1'b0;
        end

        sel_lvl  = (op_reg == OP_RUN) ? run_lvl : add_lvl;
        sel_head = head_reg[sel_lvl];
        sel_cnt  = cnt_reg[sel_lvl];

        // tail before a pop equals tail after pop plus requeue
        tail_sum  = SUM_W'(sel_head) + SUM_W'(sel_cnt);
        tail_wrap = (tail_sum >= DEPTH_S) ? (tail_sum - DEPTH_S) : tail_sum;
        wr_addr   = tail_wrap[PTR_W-1:0];

        head_entry = rdata[sel_lvl];
        run_len    = (head_entry.remaining <= q_eff) ? head_entry.remaining : q_eff;
        left_len   = head_entry.remaining - run_len;

        for (int i = 0; i < LEVELS; i++) begin
            head_next[i] = head_reg[i];
            cnt_next[i]  = cnt_reg[i];
        end
        time_next = time_reg;
        do_write  = 1'b0;
        wr_data   = '{prio: prio_reg, remaining: burst_reg};

        res_level = sel_lvl;
        res_prio  = prio_reg;
        res_run   = '0;
        res_left  = burst_reg;

        if (op_reg == OP_ADD) begin
            if (sel_cnt == DEPTH_C) begin
                res_status = ST_FULL;
            end else begin
                res_status        = ST_ADDED;
                do_write          = 1'b1;
                cnt_next[sel_lvl] = sel_cnt + 1'b1;
            end
        end else if (!any_task) begin
            res_status = ST_IDLE;
            res_level  = LVL_HIGH;
            res_prio   = '0;
            res_left   = '0;
        end else begin
            res_prio           = head_entry.prio;
            res_run            = run_len;
            res_left           = left_len;
            time_next          = time_reg + 32'(run_len);
            head_next[sel_lvl] = (sel_head == LAST_P) ? '0 : (sel_head + 1'b1);
            wr_data            = '{prio: head_entry.prio, remaining: left_len};
            if (left_len == '0) begin
                res_status        = ST_DONE;
                cnt_next[sel_lvl] = sel_cnt - 1'b1;
            end else begin
                // popped and pushed back: fill count unchanged
                res_status = ST_REQUEUED;
                do_write   = 1'b1;
            end
        end

        for (int i = 0; i < LEVELS; i++) begin
            wr_en[i] = dp_cmd.commit && do_write && (sel_lvl == level_t'(i));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            time_reg <= '0;
        end else if (dp_cmd.commit) begin
            for (int i = 0; i < LEVELS; i++) begin
                head_reg[i] <= head_next[i];
                cnt_reg[i]  <= cnt_next[i];
            end
            time_reg <= time_next;
        end
    end

    // result register
    logic    out_valid_reg;
    logic    out_valid_next;
    status_t status_reg;
    level_t  level_reg;
    prio_t   task_prio_reg;
    time_t   start_time_reg;
    burst_t  run_length_reg;
    burst_t  time_left_reg;

    assign dp_stat.out_free = !out_valid_reg || m_ready;

    always_comb begin
        priority if (dp_cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.commit) begin
            status_reg     <= res_status;
            level_reg      <= res_level;
            task_prio_reg  <= res_prio;
            start_time_reg <= time_reg;
            run_length_reg <= res_run;
            time_left_reg  <= res_left;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_status        = status_reg;
    assign m_level         = level_reg;
    assign m_task_priority = task_prio_reg;
    assign m_start_time    = start_time_reg;
    assign m_run_length    = run_length_reg;
    assign m_time_left     = time_left_reg;

endmodule

`default_nettype wire

// File: sv/multilevel_queue_rr_scheduler.sv
// Top level of the multilevel queue round-robin scheduler.
//
// Three task FIFOs (high, medium, low) of QUEUE_DEPTH entries each, held in
// on-chip memories. An add request is sorted by priority against high_limit
// and medium_limit and pushed, or reported as dropped when its FIFO is full.
// A run request pops the head of the highest non-empty FIFO, runs it for
// min(quantum, remaining time), a zero quantum counting as one, advances
// the 32-bit wrapping time counter and pushes an unfinished task back at
// the tail. Every request yields one result. In the accept cycle the heads
// of all three FIFO memories are read; afterwards, once the output register
// is free, the request executes with at most one tail write and the result
// is loaded into the output register. The block accepts no new request
// until the current one has executed; a result that is not taken holds
// execution of the following request until the output register frees.
// Configuration writes take effect at once and belong in idle periods.
`timescale 1ns / 1ps
`default_nettype none

module multilevel_queue_rr_scheduler
    import mlqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 128
)(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_operation,
    input  wire logic [7:0]            s_priority_req,
    input  wire logic [15:0]           s_burst_time,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [2:0]                 m_status,
    output logic [1:0]                 m_level,
    output logic [7:0]                 m_task_priority,
    output logic [31:0]                m_start_time,
    output logic [15:0]                m_run_length,
    output logic [15:0]                m_time_left
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    mlqs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .dp_stat (dp_stat),
        .dp_cmd  (dp_cmd)
    );

    mlqs_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_operation     (s_operation),
        .s_priority_req  (s_priority_req),
        .s_burst_time    (s_burst_time),
        .dp_cmd          (dp_cmd),
        .dp_stat         (dp_stat),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_level         (m_level),
        .m_task_priority (m_task_priority),
        .m_start_time    (m_start_time),
        .m_run_length    (m_run_length),
        .m_time_left     (m_time_left)
    );

endmodule

`default_nettype wire

// File: sv/mlqs_checker.sv
// Port-level assertions for the multilevel queue scheduler, with bind.
`timescale 1ns / 1ps
`default_nettype none

module mlqs_checker
    import mlqs_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_status,
    input wire logic [1:0]  m_level,
    input wire logic [15:0] m_run_length,
    input wire logic [15:0] m_time_left
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_time_left))
        else $error("result changed while stalled");

    // one request in flight: no accept in the cycle after an accept
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another executes");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= ST_IDLE))
        else $error("undefined status code");

    a_idle_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_IDLE) |->
            (m_level == LVL_HIGH) && (m_run_length == '0) && (m_time_left == '0))
        else $error("idle result carries task data");

    a_add_no_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_status == ST_ADDED) || (m_status == ST_FULL)) |->
            (m_run_length == '0))
        else $error("add result reports run time");

endmodule

bind multilevel_queue_rr_scheduler mlqs_checker u_mlqs_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_level      (m_level),
    .m_run_length (m_run_length),
    .m_time_left  (m_time_left)
);

`default_nettype wire
